// ===== design/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // what the cells do in a cycle
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_COMPARE,
    CMD_INSERT,
    CMD_POP,
    CMD_DELETE
  } cmd_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic signed [VALUE_W-1:0]  value;
  } ctrl_t;

  // state one cell shows to its neighbors and the top level
  typedef struct packed {
    logic                       valid;
    logic                       lt;     // stored value below the operand
    logic                       eq;     // stored value equals the operand
    logic signed [VALUE_W-1:0]  data;
  } cell_t;

endpackage

`default_nettype wire

// ===== design/spq_if.sv =====
// request and response channels of the sorted priority queue
// depends on spq_pkg for the field widths
`default_nettype none

interface spq_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic signed [spq_pkg::VALUE_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [spq_pkg::VALUE_W-1:0] result_value;
  logic [spq_pkg::POS_W-1:0]          found_position;
  logic [spq_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, status, result_value, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, result_value, found_position, entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== design/spq_cell.sv =====
// one slot of the sorted chain: holds a value, compares it, shifts with neighbors
// depends on spq_pkg
`default_nettype none

module spq_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  spq_pkg::ctrl_t      ctrl_i,
  input  spq_pkg::cell_t      prev_i,   // neighbor toward the head
  input  spq_pkg::cell_t      next_i,   // neighbor toward the tail
  output spq_pkg::cell_t      cell_o
);

  logic                                valid_q, valid_d;
  logic                                lt_q, lt_d;
  logic                                eq_q, eq_d;
  logic signed [spq_pkg::VALUE_W-1:0]  data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    data_d  = data_q;
    unique case (ctrl_i.cmd)
      spq_pkg::CMD_HOLD: begin
      end
      spq_pkg::CMD_COMPARE: begin
        lt_d = valid_q && (data_q < ctrl_i.value);
        eq_d = valid_q && (data_q == ctrl_i.value);
      end
      spq_pkg::CMD_INSERT: begin
        // cells below the operand stay, the first other one takes it, the rest move down
        if (!lt_q) begin
          if (prev_i.lt) begin
            valid_d = 1'b1;
            data_d  = ctrl_i.value;
          end else begin
            valid_d = prev_i.valid;
            data_d  = prev_i.data;
          end
        end
      end
      spq_pkg::CMD_POP: begin
        valid_d = next_i.valid;
        data_d  = next_i.data;
      end
      spq_pkg::CMD_DELETE: begin
        // matches are contiguous, so everything from the first match on moves up
        if (valid_q && !lt_q) begin
          valid_d = next_i.valid;
          data_d  = next_i.data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o = '{valid: valid_q, lt: lt_q, eq: eq_q, data: data_q};

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// top level of the sorted priority queue: sequencer, count and response register
// depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell
`default_nettype none

// sorted priority queue built as a row of DEPTH compare-and-shift cells
//
// req_i carries one request item (mode, value); rsp_o returns exactly one
// response item per request (status, result_value, found_position,
// entry_count). the head of the chain holds the smallest value.
//
// every request passes through a compare state, where all cells check their
// value against the operand in parallel, and then an update state, where the
// cells may shift one place toward or away from the head. the response is
// registered at the end of the update state. a new request is taken only in
// the idle state, so the block cannot take the next request before the last
// one has left the update state; the registered compare flags of the cell row
// and the idle handoff are the reason for this.
//
// while a response waits, the next request is still taken and compared;
// its update waits in place until the response register frees up.
// reset empties the queue at once: every cell valid bit and the count clear.

module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spq_req_if.sink     req_i,
  spq_rsp_if.source   rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e                              state_q;
  spq_pkg::mode_e                      mode_q;
  logic signed [spq_pkg::VALUE_W-1:0]  value_q;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;

  // response register
  logic                                rsp_valid_q;
  spq_pkg::status_e                    status_q, status_d;
  logic signed [spq_pkg::VALUE_W-1:0]  res_q, res_d;
  logic [IDX_W-1:0]                    pos_q, pos_d;

  spq_pkg::ctrl_t                      ctrl;
  spq_pkg::cell_t                      cells [DEPTH];

  logic                                full, empty, found, upd_go;
  logic [IDX_W-1:0]                    match_pos;
  logic signed [spq_pkg::VALUE_W-1:0]  head_keep;

  // cell row; the head sees a neighbor below every operand, the tail an empty one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_t prev_c, next_c;
    if (i == 0) begin : g_head
      assign prev_c = '{valid: 1'b0, lt: 1'b1, eq: 1'b0, data: '0};
    end else begin : g_mid
      assign prev_c = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_c = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, data: '0};
    end else begin : g_body
      assign next_c = cells[i+1];
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_c),
      .next_i (next_c),
      .cell_o (cells[i])
    );
  end

  // match flags form one contiguous run; encode where it starts
  always_comb begin
    found     = 1'b0;
    match_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | cells[i].eq;
      if (cells[i].eq && (i == 0 || !cells[(i == 0) ? 0 : i - 1].eq)) begin
        match_pos = match_pos | IDX_W'(i);
      end
    end
  end

  assign full      = (cnt_q == CNT_W'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign upd_go    = (state_q == S_UPD) && (!rsp_valid_q || rsp_o.ready);
  assign head_keep = empty ? '0 : cells[0].data;

  // cell command for the compare and update states, response contents for the update state
  always_comb begin
    ctrl.value = value_q;
    ctrl.cmd   = spq_pkg::CMD_HOLD;
    cnt_d      = cnt_q;
    status_d   = spq_pkg::STATUS_OK;
    res_d      = head_keep;
    pos_d      = '0;
    if (state_q == S_CMP) begin
      ctrl.cmd = spq_pkg::CMD_COMPARE;
    end else if (upd_go) begin
      unique case (mode_q)
        spq_pkg::MODE_INSERT: begin
          if (full) begin
            status_d = spq_pkg::STATUS_FULL;
          end else begin
            ctrl.cmd = spq_pkg::CMD_INSERT;
            cnt_d    = cnt_q + CNT_W'(1);
            res_d    = cells[0].lt ? cells[0].data : value_q;
          end
        end
        spq_pkg::MODE_POP: begin
          if (empty) begin
            status_d = spq_pkg::STATUS_EMPTY;
          end else begin
            ctrl.cmd = spq_pkg::CMD_POP;
            cnt_d    = cnt_q - CNT_W'(1);
          end
        end
        spq_pkg::MODE_DELETE: begin
          if (found) begin
            ctrl.cmd = spq_pkg::CMD_DELETE;
            cnt_d    = cnt_q - CNT_W'(1);
            // the head moves up only when the match starts at the head
            if (cnt_q == CNT_W'(1)) begin
              res_d = '0;
            end else if (!cells[0].lt) begin
              res_d = cells[1].data;
            end
          end else begin
            status_d = spq_pkg::STATUS_NOT_FOUND;
          end
        end
        spq_pkg::MODE_SEARCH: begin
          if (found) begin
            pos_d = match_pos;
          end else begin
            status_d = spq_pkg::STATUS_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer, count and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (upd_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and response payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q  <= spq_pkg::mode_e'(req_i.mode);
      value_q <= req_i.value;
    end
    if (upd_go) begin
      status_q <= status_d;
      res_q    <= res_d;
      pos_q    <= pos_d;
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.result_value   = res_q;
  assign rsp_o.found_position = spq_pkg::POS_W'(pos_q);
  assign rsp_o.entry_count    = spq_pkg::COUNT_W'(cnt_q);

endmodule

`default_nettype wire
